[sv/fct_pkg.sv]
// Shared constants and types for the frustum cull test block.
`default_nettype none

package fct_pkg;

  // Plane register file: six 64-bit registers, each packing a, b, c, d.
  localparam int unsigned NUM_PLANE_REGS = 6;
  localparam int unsigned PLANE_W        = 64;
  localparam int unsigned CFG_IDX_W      = 3;

  // Fraction bits of a coordinate; d is shifted by this to reach product scale.
  localparam int unsigned COORD_FRAC = 4;

  // Coefficient lanes inside one plane register, lowest first.
  localparam int unsigned LANE_A = 0;
  localparam int unsigned LANE_B = 1;
  localparam int unsigned LANE_C = 2;
  localparam int unsigned LANE_D = 3;

  // Defaults for the top-level parameters.
  localparam int unsigned DEF_PLANE_COUNT = 6;
  localparam int unsigned DEF_COORD_BITS  = 20;
  localparam int unsigned DEF_COEF_BITS   = 16;

  typedef logic [PLANE_W-1:0] plane_word_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PLANE_RIGHT  = 3'd0,
    REG_PLANE_LEFT   = 3'd1,
    REG_PLANE_BOTTOM = 3'd2,
    REG_PLANE_TOP    = 3'd3,
    REG_PLANE_FAR    = 3'd4,
    REG_PLANE_NEAR   = 3'd5
  } cfg_reg_e;

endpackage

`default_nettype wire

[sv/fct_plane_regs.sv]
// Plane register file: six packed plane words written through the configuration port.
`default_nettype none

module fct_plane_regs (
  input  wire logic                                       clk_i,
  input  wire logic                                       rst_ni,
  input  wire logic                                       cfg_we_i,
  input  wire logic [fct_pkg::CFG_IDX_W-1:0]              cfg_index_i,
  input  wire logic [fct_pkg::PLANE_W-1:0]                cfg_data_i,
  output fct_pkg::plane_word_t [fct_pkg::NUM_PLANE_REGS-1:0] planes_o
);

  fct_pkg::plane_word_t [fct_pkg::NUM_PLANE_REGS-1:0] planes_q;

  // Drop writes to indexes past the last plane.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      planes_q <= '0;
    end else if (cfg_we_i && (cfg_index_i <= fct_pkg::REG_PLANE_NEAR)) begin
      for (int unsigned i = 0; i < fct_pkg::NUM_PLANE_REGS; i++) begin
        if (cfg_index_i == fct_pkg::CFG_IDX_W'(i)) begin
          planes_q[i] <= cfg_data_i;
        end
      end
    end
  end

  assign planes_o = planes_q;

endmodule

`default_nettype wire

[sv/fct_plane_eval.sv]
// One plane test: best-corner value of a point or cube against a single plane.
`default_nettype none

module fct_plane_eval #(
  parameter int unsigned COORD_BITS = fct_pkg::DEF_COORD_BITS,
  parameter int unsigned COEF_BITS  = fct_pkg::DEF_COEF_BITS
) (
  input  wire fct_pkg::plane_word_t          plane_i,
  input  wire logic                          cube_i,
  input  wire logic signed [COORD_BITS-1:0]  pos_x_i,
  input  wire logic signed [COORD_BITS-1:0]  pos_y_i,
  input  wire logic signed [COORD_BITS-1:0]  pos_z_i,
  input  wire logic        [COORD_BITS-2:0]  edge_size_i,
  output logic                               pass_o
);

  localparam int unsigned PROD_W = COEF_BITS + COORD_BITS;
  localparam int unsigned PSUM_W = COEF_BITS + 1;
  localparam int unsigned EPRD_W = PSUM_W + COORD_BITS - 1;
  localparam int unsigned D16_W  = COEF_BITS + fct_pkg::COORD_FRAC;
  localparam int unsigned SUM_W  = PROD_W + 4;

  logic signed [COEF_BITS-1:0]  coef_a, coef_b, coef_c, coef_d;
  logic        [COEF_BITS-2:0]  pos_a, pos_b, pos_c;
  logic        [PSUM_W-1:0]     pos_sum;
  logic        [COORD_BITS-2:0] edge_eff;
  logic signed [PROD_W-1:0]     prod_x, prod_y, prod_z;
  logic        [EPRD_W-1:0]     prod_e;
  logic signed [D16_W-1:0]      d_scaled;
  logic signed [SUM_W-1:0]      value;

  assign coef_a = $signed(plane_i[fct_pkg::LANE_A*COEF_BITS +: COEF_BITS]);
  assign coef_b = $signed(plane_i[fct_pkg::LANE_B*COEF_BITS +: COEF_BITS]);
  assign coef_c = $signed(plane_i[fct_pkg::LANE_C*COEF_BITS +: COEF_BITS]);
  assign coef_d = $signed(plane_i[fct_pkg::LANE_D*COEF_BITS +: COEF_BITS]);

  // The corner that maximises the plane value takes the far edge on every axis
  // whose coefficient is positive, so the cube adds edge * (sum of positive coefs).
  assign pos_a   = coef_a[COEF_BITS-1] ? '0 : coef_a[COEF_BITS-2:0];
  assign pos_b   = coef_b[COEF_BITS-1] ? '0 : coef_b[COEF_BITS-2:0];
  assign pos_c   = coef_c[COEF_BITS-1] ? '0 : coef_c[COEF_BITS-2:0];
  assign pos_sum = PSUM_W'(pos_a) + PSUM_W'(pos_b) + PSUM_W'(pos_c);
  assign edge_eff = cube_i ? edge_size_i : '0;

  assign prod_x   = coef_a * pos_x_i;
  assign prod_y   = coef_b * pos_y_i;
  assign prod_z   = coef_c * pos_z_i;
  assign prod_e   = EPRD_W'(edge_eff) * EPRD_W'(pos_sum);
  assign d_scaled = {coef_d, fct_pkg::COORD_FRAC'(0)};

  assign value = SUM_W'(prod_x) + SUM_W'(prod_y) + SUM_W'(prod_z)
               + SUM_W'(d_scaled) + SUM_W'($signed({1'b0, prod_e}));

  // Zero counts as outside.
  assign pass_o = !value[SUM_W-1] && (value != '0);

endmodule

`default_nettype wire

[sv/frustum_cull_test_top.sv]
// Top level of the frustum cull test: input register, plane tests, result register.
`default_nettype none

// Tests one point or axis-aligned cube per word against up to six view planes
// held in configuration registers (right, left, bottom, top, far, near at
// indexes 0 to 5; a, b, c, d as signed Q8.8 lanes, a lowest). A point is
// visible when every plane value a*x+b*y+c*z+16*d is above zero; a cube is
// dropped only when all eight corners of some plane give zero or less, which
// is found by testing the single best corner of each plane. One word is taken
// every cycle while in_stall_o is low: it lands in the input register, all
// plane units evaluate it in parallel in one pass, and the verdict then lands
// in the result register. The input register keeps taking words while a
// result waits, up to one held word. Write planes only while the block is
// idle; after reset all planes are zero and everything reports not visible.
module frustum_cull_test_top #(
  parameter int unsigned PLANE_COUNT = fct_pkg::DEF_PLANE_COUNT,
  parameter int unsigned COORD_BITS  = fct_pkg::DEF_COORD_BITS,
  parameter int unsigned COEF_BITS   = fct_pkg::DEF_COEF_BITS
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // configuration write port
  input  wire logic                                cfg_we_i,
  input  wire logic [fct_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire logic [fct_pkg::PLANE_W-1:0]         cfg_data_i,
  // input channel
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic                                operation_i,
  input  wire logic signed [COORD_BITS-1:0]        pos_x_i,
  input  wire logic signed [COORD_BITS-1:0]        pos_y_i,
  input  wire logic signed [COORD_BITS-1:0]        pos_z_i,
  input  wire logic        [COORD_BITS-2:0]        edge_size_i,
  // result channel
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic                                     visible_o
);

  fct_pkg::plane_word_t [fct_pkg::NUM_PLANE_REGS-1:0] planes;

  logic                          in_valid_q;
  logic                          op_q;
  logic signed [COORD_BITS-1:0]  pos_x_q, pos_y_q, pos_z_q;
  logic        [COORD_BITS-2:0]  edge_q;
  logic                          out_valid_q;
  logic                          visible_q;
  logic        [PLANE_COUNT-1:0] plane_pass;
  logic                          out_adv;
  logic                          in_take;

  fct_plane_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .planes_o    (planes)
  );

  // Result register is free when empty or being taken this cycle.
  assign out_adv    = !out_valid_q || !out_stall_i;
  // Hold the input word only when it cannot move on to the result register.
  assign in_stall_o = in_valid_q && !out_adv;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      op_q    <= operation_i;
      pos_x_q <= pos_x_i;
      pos_y_q <= pos_y_i;
      pos_z_q <= pos_z_i;
      edge_q  <= edge_size_i;
    end
  end

  // One test unit per active plane, all working on the same word.
  for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_plane
    fct_plane_eval #(
      .COORD_BITS (COORD_BITS),
      .COEF_BITS  (COEF_BITS)
    ) u_eval (
      .plane_i     (planes[p]),
      .cube_i      (op_q),
      .pos_x_i     (pos_x_q),
      .pos_y_i     (pos_y_q),
      .pos_z_i     (pos_z_q),
      .edge_size_i (edge_q),
      .pass_o      (plane_pass[p])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_adv) begin
      out_valid_q <= in_valid_q;
    end
  end

  // Visible only when every plane passes.
  always_ff @(posedge clk_i) begin
    if (out_adv && in_valid_q) begin
      visible_q <= &plane_pass;
    end
  end

  assign out_valid_o = out_valid_q;
  assign visible_o   = visible_q;

  // A word in the input register moves to the result register when it is free.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_adv) |=> out_valid_q)
    else $error("input word lost on its way to the result register");

  // With nothing behind it, a taken result leaves the result register empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_stall_i && !in_valid_q) |=> !out_valid_q)
    else $error("result repeated after being taken");

  // Back-pressure reaches the input only when both registers are full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled without a full pipeline");

endmodule

`default_nettype wire

[tb/sv/frustum_cull_checker.sv]
// Checker for the frustum cull test: mirrors the plane registers, predicts and compares verdicts.
`default_nettype none

module frustum_cull_checker
  import fct_pkg::*;
#(
  parameter int unsigned PLANE_COUNT = DEF_PLANE_COUNT,
  parameter int unsigned COORD_BITS  = DEF_COORD_BITS,
  parameter int unsigned COEF_BITS   = DEF_COEF_BITS
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]         cfg_index_i,
  input  wire logic [PLANE_W-1:0]           cfg_data_i,
  input  wire logic                         in_valid_i,
  input  wire logic                         in_stall_i,
  input  wire logic                         operation_i,
  input  wire logic signed [COORD_BITS-1:0] pos_x_i,
  input  wire logic signed [COORD_BITS-1:0] pos_y_i,
  input  wire logic signed [COORD_BITS-1:0] pos_z_i,
  input  wire logic        [COORD_BITS-2:0] edge_size_i,
  input  wire logic                         out_valid_i,
  input  wire logic                         out_stall_i,
  input  wire logic                         visible_i,
  output int                                fail_count_o,
  output int                                pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  plane_word_t plane_copy [NUM_PLANE_REGS];
  bit          verdict_due [$];
  int          mismatches;
  bit          want;

  // Exact plane value at product scale: a*x + b*y + c*z + d shifted up to match.
  function automatic longint plane_sum(plane_word_t w, longint x, longint y, longint z);
    longint a, b, c, d;
    a = $signed(w[LANE_A*COEF_BITS +: COEF_BITS]);
    b = $signed(w[LANE_B*COEF_BITS +: COEF_BITS]);
    c = $signed(w[LANE_C*COEF_BITS +: COEF_BITS]);
    d = $signed(w[LANE_D*COEF_BITS +: COEF_BITS]);
    return a * x + b * y + c * z + (d <<< COORD_FRAC);
  endfunction

  // A point must be strictly inside every plane; a cube is dropped only when
  // some plane has all eight corners on or behind it.
  function automatic bit predict_visible(bit is_cube, logic signed [COORD_BITS-1:0] x,
                                         logic signed [COORD_BITS-1:0] y,
                                         logic signed [COORD_BITS-1:0] z,
                                         logic [COORD_BITS-2:0] e);
    longint px, py, pz, pe;
    bit     seen;
    px = x;
    py = y;
    pz = z;
    pe = e;
    for (int p = 0; p < PLANE_COUNT && p < NUM_PLANE_REGS; p++) begin
      if (!is_cube) begin
        if (plane_sum(plane_copy[p], px, py, pz) <= 0) return 1'b0;
      end else begin
        seen = 1'b0;
        for (int k = 0; k < 8; k++) begin
          if (plane_sum(plane_copy[p], px + (k[0] ? pe : 64'sd0), py + (k[1] ? pe : 64'sd0),
                        pz + (k[2] ? pe : 64'sd0)) > 0) seen = 1'b1;
        end
        if (!seen) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (plane_copy[i]) plane_copy[i] = '0;
      verdict_due.delete();
      mismatches = 0;
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (in_valid_i && !in_stall_i)
        verdict_due.push_back(predict_visible(operation_i, pos_x_i, pos_y_i, pos_z_i,
                                              edge_size_i));
      if (out_valid_i && !out_stall_i) begin
        if (verdict_due.size() == 0) begin
          $display("%0t ns: unexpected verdict: expected none, actual visible=%b",
                   $time, visible_i);
          mismatches++;
        end else begin
          want = verdict_due.pop_front();
          if (visible_i !== want) begin
            $display("%0t ns: visible mismatch: expected %b, actual %b", $time, want,
                     visible_i);
            mismatches++;
          end
        end
      end
      // planes change only while idle, so the update order against words is moot
      if (cfg_we_i && cfg_index_i < NUM_PLANE_REGS) plane_copy[cfg_index_i] = cfg_data_i;
      fail_count_o <= mismatches;
      pending_o <= verdict_due.size();
    end
  end

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
// Top of the frustum cull test bench: clock, reset, plane set-up, word stimulus and verdict.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COORD_BITS = fct_pkg::DEF_COORD_BITS;
  localparam int COEF_BITS  = fct_pkg::DEF_COEF_BITS;

  localparam logic OP_POINT = 1'b0;
  localparam logic OP_CUBE  = 1'b1;

  // Indexes past the plane file; writes there must leave every plane alone.
  localparam logic [fct_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_LO = 3'd6;
  localparam logic [fct_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;

  localparam int COORD_MAX = (1 << (COORD_BITS - 1)) - 1;
  localparam int COORD_MIN = -(1 << (COORD_BITS - 1));
  localparam int EDGE_MAX  = (1 << (COORD_BITS - 1)) - 1;
  localparam int COEF_MAX  = (1 << (COEF_BITS - 1)) - 1;
  localparam int COEF_MIN  = -(1 << (COEF_BITS - 1));

  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_WORDS   = 110;
  localparam int SETTLE_CYCLES = 4;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic        [COORD_BITS-2:0] span_t;

  logic                          clk;
  logic                          rst_n = 1'b0;
  logic                          cfg_we = 1'b0;
  logic [fct_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  fct_pkg::plane_word_t          cfg_data = '0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic                          operation = OP_POINT;
  coord_t                        pos_x = '0;
  coord_t                        pos_y = '0;
  coord_t                        pos_z = '0;
  span_t                         edge_size = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic                          visible;
  int                            fail_count;
  int                            pending;
  logic [8:0]                    stall_tick = '0;

  fct_pkg::plane_word_t plane_set [fct_pkg::NUM_PLANE_REGS];

  frustum_cull_test_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .operation_i (operation),
    .pos_x_i     (pos_x),
    .pos_y_i     (pos_y),
    .pos_z_i     (pos_z),
    .edge_size_i (edge_size),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .visible_o   (visible)
  );

  frustum_cull_checker cull_watch (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .operation_i  (operation),
    .pos_x_i      (pos_x),
    .pos_y_i      (pos_y),
    .pos_z_i      (pos_z),
    .edge_size_i  (edge_size),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .visible_i    (visible),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Result side: cycle through four stall moods - open, light random, heavy
  // random and a fixed on/off beat - so that stalls land on every stage of
  // the pipe and there are long open stretches too.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_tick <= '0;
    end else begin
      stall_tick <= stall_tick + 1'b1;
      case (stall_tick[8:7])
        2'd0: out_stall <= 1'b0;
        2'd1: out_stall <= ($urandom_range(3) == 0);
        2'd2: out_stall <= ($urandom_range(3) != 0);
        default: out_stall <= stall_tick[2];
      endcase
    end
  end

  // Hard stop, far beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

  // Symmetric random value in [-r, r].
  function automatic int spread(int r);
    return int'($urandom_range(2 * r)) - r;
  endfunction

  function automatic int extreme_coord();
    case ($urandom_range(4))
      0: return COORD_MAX;
      1: return COORD_MIN;
      2: return 0;
      3: return -1;
      default: return 1;
    endcase
  endfunction

  function automatic int extreme_coef();
    case ($urandom_range(4))
      0: return COEF_MAX;
      1: return COEF_MIN;
      2: return 0;
      3: return -1;
      default: return 1;
    endcase
  endfunction

  // Pack four coefficients into one plane word, a in the lowest lane.
  function automatic fct_pkg::plane_word_t pack_plane(int a, int b, int c, int d);
    return {COEF_BITS'(d), COEF_BITS'(c), COEF_BITS'(b), COEF_BITS'(a)};
  endfunction

  function automatic int lean(int scale, bit tilted);
    return tilted ? spread(scale) : 0;
  endfunction

  // Build a box of half-width 'half' (coordinate steps) around the origin.
  // The axis coefficient is scale*16 and d is scale*half, so each plane sits
  // exactly at +/-half; a tilt adds small cross terms to skew the faces.
  function automatic void set_box(int half, int scale, bit tilted);
    int unit, offset;
    unit = scale << fct_pkg::COORD_FRAC;
    offset = scale * half;
    plane_set[fct_pkg::REG_PLANE_RIGHT]  = pack_plane(-unit, lean(scale, tilted),
                                                      lean(scale, tilted), offset);
    plane_set[fct_pkg::REG_PLANE_LEFT]   = pack_plane(unit, lean(scale, tilted),
                                                      lean(scale, tilted), offset);
    plane_set[fct_pkg::REG_PLANE_BOTTOM] = pack_plane(lean(scale, tilted), unit,
                                                      lean(scale, tilted), offset);
    plane_set[fct_pkg::REG_PLANE_TOP]    = pack_plane(lean(scale, tilted), -unit,
                                                      lean(scale, tilted), offset);
    plane_set[fct_pkg::REG_PLANE_FAR]    = pack_plane(lean(scale, tilted),
                                                      lean(scale, tilted), -unit, offset);
    plane_set[fct_pkg::REG_PLANE_NEAR]   = pack_plane(lean(scale, tilted),
                                                      lean(scale, tilted), unit, offset);
  endfunction

  // Write all six planes, then junk to both unmapped indexes, then drop the enable.
  task automatic program_planes();
    for (int i = 0; i < fct_pkg::NUM_PLANE_REGS; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= fct_pkg::CFG_IDX_W'(i);
      cfg_data <= plane_set[i];
      @(posedge clk);
    end
    cfg_index <= REG_UNMAPPED_LO;
    cfg_data <= {$urandom, $urandom};
    @(posedge clk);
    cfg_index <= REG_UNMAPPED_HI;
    cfg_data <= {$urandom, $urandom};
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Present one word and hold it until the block takes it.
  task automatic send_word(input logic op, input int x, input int y, input int z, input int e);
    in_valid <= 1'b1;
    operation <= op;
    pos_x <= coord_t'(x);
    pos_y <= coord_t'(y);
    pos_z <= coord_t'(z);
    edge_size <= span_t'(e);
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Mostly words around the box, some over the full range, a few at the limits.
  task automatic send_random_word(input int reach);
    int pick, x, y, z, e;
    pick = $urandom_range(9);
    if (pick <= 6) begin
      x = spread(reach);
      y = spread(reach);
      z = spread(reach);
    end else if (pick <= 8) begin
      x = $urandom;
      y = $urandom;
      z = $urandom;
    end else begin
      x = extreme_coord();
      y = extreme_coord();
      z = extreme_coord();
    end
    pick = $urandom_range(9);
    if (pick <= 6) e = $urandom_range(reach);
    else if (pick <= 8) e = $urandom;
    else e = $urandom_range(1) ? EDGE_MAX : 0;
    send_word($urandom_range(1) ? OP_CUBE : OP_POINT, x, y, z, e);
  endtask

  // Stop sending and hold until every verdict is back and the pipe is empty.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int half, reach, burst_left, gap, pick;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Planes straight out of reset are all zero: nothing may be visible.
    send_word(OP_POINT, 0, 0, 0, 0);
    send_word(OP_CUBE, COORD_MIN, COORD_MIN, COORD_MIN, EDGE_MAX);
    drain();

    // Axis-aligned box of half-width 100 steps; value is zero right on a face.
    set_box(100, 16, 1'b0);
    program_planes();
    send_word(OP_POINT, 0, 0, 0, 0);
    send_word(OP_POINT, 99, -99, 99, 0);
    send_word(OP_POINT, 100, 0, 0, 0);                 // on the right face: outside
    send_word(OP_POINT, 0, -100, 0, 0);                // on the bottom face: outside
    send_word(OP_POINT, 0, 0, 99, EDGE_MAX);           // edge ignored for a point
    send_word(OP_CUBE, -200, -50, -50, 100);           // far corner touches left face
    send_word(OP_CUBE, -200, -50, -50, 101);           // one step further gets in
    send_word(OP_CUBE, -300, -300, -300, 600);         // cube swallows the box
    send_word(OP_CUBE, COORD_MAX, 0, 0, EDGE_MAX);     // x + edge must not wrap
    send_word(OP_CUBE, COORD_MIN, COORD_MIN, COORD_MIN, EDGE_MAX);
    send_word(OP_POINT, COORD_MAX, COORD_MAX, COORD_MAX, 0);
    send_word(OP_POINT, COORD_MIN, COORD_MIN, COORD_MIN, 0);
    send_word(OP_CUBE, 50, 50, 50, 0);                 // zero-size cube
    drain();

    // Widest products: every lane at its positive, then its negative limit.
    foreach (plane_set[i]) plane_set[i] = pack_plane(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
    program_planes();
    send_word(OP_POINT, COORD_MAX, COORD_MAX, COORD_MAX, 0);
    send_word(OP_POINT, COORD_MIN, COORD_MIN, COORD_MIN, 0);
    send_word(OP_CUBE, COORD_MIN, COORD_MIN, COORD_MIN, EDGE_MAX);
    drain();
    foreach (plane_set[i]) plane_set[i] = pack_plane(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
    program_planes();
    send_word(OP_POINT, COORD_MIN, COORD_MIN, COORD_MIN, 0);
    send_word(OP_POINT, COORD_MAX, COORD_MAX, COORD_MAX, 0);
    drain();

    // Random phases: each loads a new plane set, streams words in bursts with
    // random gaps, then drains completely before the next set goes in.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph % 4)
        0: begin
          half = $urandom_range(2047, 4);
          set_box(half, $urandom_range(15, 1), 1'b1);
          reach = 2 * half;
        end
        1: begin
          foreach (plane_set[i]) plane_set[i] = {$urandom, $urandom};
          reach = 4096;
        end
        2: begin
          foreach (plane_set[i])
            plane_set[i] = pack_plane(extreme_coef(), extreme_coef(), extreme_coef(),
                                      extreme_coef());
          reach = 4096;
        end
        default: begin
          half = $urandom_range(64, 1);
          set_box(half, 15, 1'b0);
          plane_set[$urandom_range(fct_pkg::NUM_PLANE_REGS - 1)] = {$urandom, $urandom};
          reach = 2 * half;
        end
      endcase
      program_planes();

      burst_left = 0;
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (burst_left == 0) begin
          // pick the gap before the next burst; zero keeps valid high throughout
          pick = $urandom_range(9);
          gap = (pick < 4) ? 0 : (pick < 8) ? $urandom_range(3, 1) : $urandom_range(24, 4);
          if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
          end
          burst_left = ($urandom_range(7) == 0) ? $urandom_range(150, 60)
                                                : $urandom_range(12, 1);
        end
        send_random_word(reach);
        burst_left--;
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
sv/fct_pkg.sv
sv/fct_plane_regs.sv
sv/fct_plane_eval.sv
sv/frustum_cull_test_top.sv
tb/sv/frustum_cull_checker.sv
tb/sv/testbench.sv
